[rtl/core/assert_macros.svh]
// Assertion helpers, clocked on clk_i and quiet while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/core/mme_pkg.sv]
// ----------------------------------------------------------------------------
// mme_pkg
// Types, constants and helpers shared by the matrix multiply engine.
// ----------------------------------------------------------------------------
`default_nettype none

package mme_pkg;

  localparam int MAX_DIM    = 8;
  localparam int ELEM_WIDTH = 16;

  localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int ADDR_W = 2 * IDX_W;
  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int CFG_W  = 4;
  localparam int CIDX_W = 2;
  localparam int ACT_W  = 2;
  localparam int MUL_W  = 2 * ELEM_WIDTH;
  localparam int PROD_W = MUL_W + 3;

  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD_A  = 2'd0,
    ACT_LOAD_B  = 2'd1,
    ACT_COMPUTE = 2'd2
  } action_e;

  typedef enum logic [CIDX_W-1:0] {
    REG_ROWS_A    = 2'd0,
    REG_INNER_DIM = 2'd1,
    REG_COLS_B    = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_RUN,
    SEQ_DRAIN
  } seq_state_e;

  // One issued multiply-accumulate step
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last_k;
    logic             last_entry;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } mme_tag_t;

  // Size register as used: zero counts as one, large values clamp
  function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (32'(v) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/core/mme_ram.sv]
// ----------------------------------------------------------------------------
// mme_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mme_ram #(
  parameter int DATA_W = 16,
  parameter int ADDR_W = 6
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [2**ADDR_W];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/core/mme_seq.sv]
// ----------------------------------------------------------------------------
// mme_seq
// Walks i, j, k over the result and issues one read pair per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mme_seq
  import mme_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             go_i,
  input  wire logic             done_i,
  input  wire logic [DIM_W-1:0] nr_i,
  input  wire logic [DIM_W-1:0] nk_i,
  input  wire logic [DIM_W-1:0] nc_i,
  output logic                  busy_o,
  output mme_tag_t              tag_o,
  output logic [IDX_W-1:0]      k_o
);

  seq_state_e state_q, state_d;
  logic [IDX_W-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic k_end, j_end, i_end, run;

  assign k_end = DIM_W'(k_q) == nk_i - DIM_W'(1);
  assign j_end = DIM_W'(j_q) == nc_i - DIM_W'(1);
  assign i_end = DIM_W'(i_q) == nr_i - DIM_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    run     = 1'b0;
    unique case (state_q)
      SEQ_IDLE: begin
        if (go_i) state_d = SEQ_RUN;
      end
      SEQ_RUN: begin
        run = 1'b1;
        if (k_end && j_end && i_end) state_d = SEQ_DRAIN;
      end
      SEQ_DRAIN: begin
        if (done_i) state_d = SEQ_IDLE;
      end
      default: state_d = SEQ_IDLE;
    endcase
  end

  always_comb begin
    i_d = i_q;
    j_d = j_q;
    k_d = k_q;
    if (go_i && state_q == SEQ_IDLE) begin
      i_d = '0;
      j_d = '0;
      k_d = '0;
    end else if (run) begin
      if (k_end) begin
        k_d = '0;
        if (j_end) begin
          j_d = '0;
          i_d = i_q + IDX_W'(1);
        end else begin
          j_d = j_q + IDX_W'(1);
        end
      end else begin
        k_d = k_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q <= '0;
      j_q <= '0;
      k_q <= '0;
    end else begin
      i_q <= i_d;
      j_q <= j_d;
      k_q <= k_d;
    end
  end

  assign busy_o           = state_q != SEQ_IDLE;
  assign tag_o.valid      = run;
  assign tag_o.first      = k_q == '0;
  assign tag_o.last_k     = k_end;
  assign tag_o.last_entry = j_end && i_end;
  assign tag_o.row        = i_q;
  assign tag_o.col        = j_q;
  assign k_o              = k_q;

endmodule

`default_nettype wire

[rtl/core/mme_mac.sv]
// ----------------------------------------------------------------------------
// mme_mac
// Shared multiply-accumulate unit: multiply stage, accumulate stage and
// the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mme_mac
  import mme_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  mme_tag_t                     tag_i,
  input  wire logic [ELEM_WIDTH-1:0]   a_i,
  input  wire logic [ELEM_WIDTH-1:0]   b_i,
  output logic                         valid_o,
  output logic signed [PROD_W-1:0]     value_o,
  output logic [IDX_W-1:0]             row_o,
  output logic [IDX_W-1:0]             col_o,
  output logic                         last_o
);

  mme_tag_t tag_s1_q, tag_s2_q;
  logic signed [MUL_W-1:0]  prod_q;
  logic signed [PROD_W-1:0] acc_q, acc_d;
  logic signed [PROD_W-1:0] value_q;
  logic [IDX_W-1:0]         row_q, col_q;
  logic                     valid_q, last_q;

  // tag_s1 lines up with the registered RAM data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_s1_q <= '0;
      tag_s2_q <= '0;
      valid_q  <= 1'b0;
    end else begin
      tag_s1_q <= tag_i;
      tag_s2_q <= tag_s1_q;
      valid_q  <= tag_s2_q.valid && tag_s2_q.last_k;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= MUL_W'($signed(a_i) * $signed(b_i));
  end

  always_comb begin
    if (tag_s2_q.first) begin
      acc_d = PROD_W'(prod_q);
    end else begin
      acc_d = acc_q + PROD_W'(prod_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (tag_s2_q.valid) begin
      acc_q <= acc_d;
    end
    if (tag_s2_q.valid && tag_s2_q.last_k) begin
      value_q <= acc_d;
      row_q   <= tag_s2_q.row;
      col_q   <= tag_s2_q.col;
      last_q  <= tag_s2_q.last_entry;
    end
  end

  assign valid_o = valid_q;
  assign value_o = value_q;
  assign row_o   = row_q;
  assign col_o   = col_q;
  assign last_o  = last_q;

endmodule

`default_nettype wire

[rtl/core/matrix_multiply_engine.sv]
// ----------------------------------------------------------------------------
// matrix_multiply_engine
// Dense C = A x B on signed Q8.8 elements held in two on-chip RAMs.
// ----------------------------------------------------------------------------
// Requests enter on start_i while busy_o is low: action_i selects a load of
// an A element, a load of a B element, or a compute. A load is written at
// the accepting edge; loads outside the configured sizes are dropped, and
// an unused action is ignored.
// A compute raises busy_o and emits every entry of C in row-major order,
// one per valid_o pulse, with last_o on the final one. Each entry is the
// exact Q16.16 sum, 35 bits signed.
// One shared multiply-accumulate unit does one product per cycle, fed by
// one read of each RAM per cycle, so a compute issues rows*cols*inner
// products; each sum passes the RAM read, product and result registers.
// busy_o falls the cycle after the last entry.
// Size registers (cfg_we_i/cfg_idx_i/cfg_data_i) reset to 8, zero acts as 1;
// users must write them only while the engine is idle; it does not check.
// Reset returns the sequencer to idle; matrix contents are undefined until
// loaded. The receiver cannot stall: each result is held for one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module matrix_multiply_engine
  import mme_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [CIDX_W-1:0]       cfg_idx_i,
  input  wire logic [CFG_W-1:0]        cfg_data_i,
  input  wire logic                    start_i,
  output logic                         busy_o,
  input  wire logic [ACT_W-1:0]        action_i,
  input  wire logic [IDX_W-1:0]        row_index_i,
  input  wire logic [IDX_W-1:0]        col_index_i,
  input  wire logic signed [ELEM_WIDTH-1:0] element_value_i,
  output logic                         valid_o,
  output logic signed [PROD_W-1:0]     product_value_o,
  output logic [IDX_W-1:0]             out_row_o,
  output logic [IDX_W-1:0]             out_col_o,
  output logic                         last_o
);

  logic [CFG_W-1:0] rows_a_q, inner_dim_q, cols_b_q;
  logic [DIM_W-1:0] nr, nk, nc;
  logic             accept, go, we_a, we_b;
  logic [ADDR_W-1:0] waddr, raddr_a, raddr_b;
  logic [ELEM_WIDTH-1:0] a_rdata, b_rdata;
  mme_tag_t         tag;
  logic [IDX_W-1:0] k;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q    <= CFG_W'(MAX_DIM);
      inner_dim_q <= CFG_W'(MAX_DIM);
      cols_b_q    <= CFG_W'(MAX_DIM);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ROWS_A:    rows_a_q    <= cfg_data_i;
        REG_INNER_DIM: inner_dim_q <= cfg_data_i;
        REG_COLS_B:    cols_b_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign nr = eff_dim(rows_a_q);
  assign nk = eff_dim(inner_dim_q);
  assign nc = eff_dim(cols_b_q);

  assign accept = start_i && !busy_o;
  assign go     = accept && action_i == ACT_COMPUTE;
  assign we_a   = accept && action_i == ACT_LOAD_A
                  && DIM_W'(row_index_i) < nr && DIM_W'(col_index_i) < nk;
  assign we_b   = accept && action_i == ACT_LOAD_B
                  && DIM_W'(row_index_i) < nk && DIM_W'(col_index_i) < nc;
  assign waddr  = {row_index_i, col_index_i};

  assign raddr_a = {tag.row, k};
  assign raddr_b = {k, tag.col};

  mme_ram #(.DATA_W(ELEM_WIDTH), .ADDR_W(ADDR_W)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (waddr),
    .wdata_i (element_value_i),
    .raddr_i (raddr_a),
    .rdata_o (a_rdata)
  );

  mme_ram #(.DATA_W(ELEM_WIDTH), .ADDR_W(ADDR_W)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (waddr),
    .wdata_i (element_value_i),
    .raddr_i (raddr_b),
    .rdata_o (b_rdata)
  );

  mme_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (go),
    .done_i (valid_o && last_o),
    .nr_i   (nr),
    .nk_i   (nk),
    .nc_i   (nc),
    .busy_o (busy_o),
    .tag_o  (tag),
    .k_o    (k)
  );

  mme_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tag_i   (tag),
    .a_i     (a_rdata),
    .b_i     (b_rdata),
    .valid_o (valid_o),
    .value_o (product_value_o),
    .row_o   (out_row_o),
    .col_o   (out_col_o),
    .last_o  (last_o)
  );

  // results only appear inside a compute
  `ASSERT_IMPL(a_result_busy, valid_o, busy_o)
  // engine is idle straight after the final entry
  `ASSERT_NEXT(a_last_idle, valid_o && last_o, !busy_o)
  // a compute request always starts the sequencer
  `ASSERT_NEXT(a_compute_busy, go, busy_o)
  // no RAM write while a compute is under way
  `ASSERT_IMPL(a_no_load_busy, busy_o, !we_a && !we_b)

endmodule

`default_nettype wire

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the matrix multiply engine: loads A and B through
// the request port, issues computes and checks every C entry against a local
// fixed-point model of the engine.
// ----------------------------------------------------------------------------
module tb;
  import mme_pkg::*;

  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam logic signed [ELEM_WIDTH-1:0] ELEM_MIN = 16'sh8000;
  localparam logic signed [ELEM_WIDTH-1:0] ELEM_MAX = 16'sh7fff;
  localparam int ITEMS_TARGET   = 250;
  localparam int QUIET_ITEMS    = 40;
  localparam int SETTLE_CYCLES  = 12;
  localparam int DRAIN_CYCLES   = 20;
  localparam int TIMEOUT_CYCLES = 400_000;
  localparam int NUM_ELEMS      = MAX_DIM * MAX_DIM;

  typedef enum logic [1:0] {
    SEND_REQ,
    SEND_CFG,
    SEND_HOLD
  } send_kind_e;

  typedef struct {
    send_kind_e                   kind;
    logic [ACT_W-1:0]             act;
    logic [IDX_W-1:0]             row;
    logic [IDX_W-1:0]             col;
    logic signed [ELEM_WIDTH-1:0] value;
    reg_idx_e                     cfg_idx;
    logic [CFG_W-1:0]             cfg_val;
    int unsigned                  gap;
  } send_t;

  typedef struct {
    logic signed [PROD_W-1:0] value;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic                     last;
  } c_entry_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                         cfg_we_i        = 1'b0;
  logic [CIDX_W-1:0]            cfg_idx_i       = REG_ROWS_A;
  logic [CFG_W-1:0]             cfg_data_i      = '0;
  logic                         start_i         = 1'b0;
  logic [ACT_W-1:0]             action_i        = ACT_LOAD_A;
  logic [IDX_W-1:0]             row_index_i     = '0;
  logic [IDX_W-1:0]             col_index_i     = '0;
  logic signed [ELEM_WIDTH-1:0] element_value_i = '0;
  logic                         busy_o;
  logic                         valid_o;
  logic signed [PROD_W-1:0]     product_value_o;
  logic [IDX_W-1:0]             out_row_o;
  logic [IDX_W-1:0]             out_col_o;
  logic                         last_o;

  matrix_multiply_engine dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .action_i       (action_i),
    .row_index_i    (row_index_i),
    .col_index_i    (col_index_i),
    .element_value_i(element_value_i),
    .valid_o        (valid_o),
    .product_value_o(product_value_o),
    .out_row_o      (out_row_o),
    .out_col_o      (out_col_o),
    .last_o         (last_o)
  );

  always #5 clk_i = ~clk_i;

  send_t    send_q[$];
  c_entry_t c_entries_due[$];
  int       mismatches = 0;
  int       settle     = 0;

  // engine state as seen by the checker
  logic signed [ELEM_WIDTH-1:0] a_mem[NUM_ELEMS];
  logic signed [ELEM_WIDTH-1:0] b_mem[NUM_ELEMS];
  logic [CFG_W-1:0]             rows_reg  = 4'd8;
  logic [CFG_W-1:0]             inner_reg = 4'd8;
  logic [CFG_W-1:0]             cols_reg  = 4'd8;

  // generator's view, used to keep computes off unwritten elements
  logic [CFG_W-1:0] gen_rows  = 4'd8;
  logic [CFG_W-1:0] gen_inner = 4'd8;
  logic [CFG_W-1:0] gen_cols  = 4'd8;
  bit               a_loaded[NUM_ELEMS];
  bit               b_loaded[NUM_ELEMS];
  int               item_count = 0;
  bit               quiet      = 1'b0;
  bit               bursty     = 1'b1;

  // zero counts as one, anything past MAX_DIM clamps
  function automatic logic [CFG_W-1:0] used_dim(input logic [CFG_W-1:0] v);
    if (v == '0) return 4'd1;
    if (v > MAX_DIM) return CFG_W'(MAX_DIM);
    return v;
  endfunction

  function automatic logic signed [ELEM_WIDTH-1:0] rand_elem();
    case ($urandom_range(0, 7))
      0: return ELEM_MIN;
      1: return ELEM_MAX;
      2: return '0;
      default: return ELEM_WIDTH'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] rand_size();
    case ($urandom_range(0, 9))
      0: return 4'd0;
      1: return 4'd15;
      2: return 4'd8;
      3: return 4'd1;
      default: return CFG_W'($urandom_range(2, 5));
    endcase
  endfunction

  task automatic engine_step(input send_t s);
    logic [CFG_W-1:0]         nr, nk, nc;
    logic signed [PROD_W-1:0] acc;
    logic signed [MUL_W-1:0]  prod;
    c_entry_t                 e;
    nr = used_dim(rows_reg);
    nk = used_dim(inner_reg);
    nc = used_dim(cols_reg);
    case (s.act)
      ACT_LOAD_A: if (s.row < nr && s.col < nk) a_mem[{s.row, s.col}] = s.value;
      ACT_LOAD_B: if (s.row < nk && s.col < nc) b_mem[{s.row, s.col}] = s.value;
      ACT_COMPUTE: begin
        for (int i = 0; i < nr; i++) begin
          for (int j = 0; j < nc; j++) begin
            acc = '0;
            for (int k = 0; k < nk; k++) begin
              prod = a_mem[i * MAX_DIM + k] * b_mem[k * MAX_DIM + j];
              acc  = acc + prod;
            end
            e.value = acc;
            e.row   = IDX_W'(i);
            e.col   = IDX_W'(j);
            e.last  = (i == nr - 1) && (j == nc - 1);
            c_entries_due.push_back(e);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic queue_req(input logic [ACT_W-1:0] act, input logic [IDX_W-1:0] r,
                           input logic [IDX_W-1:0] c,
                           input logic signed [ELEM_WIDTH-1:0] v);
    send_t s;
    s.kind    = SEND_REQ;
    s.act     = act;
    s.row     = r;
    s.col     = c;
    s.value   = v;
    s.cfg_idx = REG_ROWS_A;
    s.cfg_val = '0;
    s.gap     = (!quiet && bursty && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
    if (act == ACT_LOAD_A && r < used_dim(gen_rows) && c < used_dim(gen_inner))
      a_loaded[{r, c}] = 1'b1;
    if (act == ACT_LOAD_B && r < used_dim(gen_inner) && c < used_dim(gen_cols))
      b_loaded[{r, c}] = 1'b1;
    if (act != ACT_UNUSED) item_count++;
    send_q.push_back(s);
  endtask

  task automatic queue_cfg(input reg_idx_e idx, input logic [CFG_W-1:0] v);
    send_t s;
    s.kind    = SEND_CFG;
    s.act     = ACT_LOAD_A;
    s.row     = '0;
    s.col     = '0;
    s.value   = '0;
    s.cfg_idx = idx;
    s.cfg_val = v;
    s.gap     = 0;
    case (idx)
      REG_ROWS_A:    gen_rows  = v;
      REG_INNER_DIM: gen_inner = v;
      REG_COLS_B:    gen_cols  = v;
      default: ;
    endcase
    send_q.push_back(s);
  endtask

  task automatic queue_hold();
    send_t s;
    s.kind    = SEND_HOLD;
    s.act     = ACT_LOAD_A;
    s.row     = '0;
    s.col     = '0;
    s.value   = '0;
    s.cfg_idx = REG_ROWS_A;
    s.cfg_val = '0;
    s.gap     = 0;
    send_q.push_back(s);
  endtask

  // fill every element the next compute will read, reloading some already loaded
  task automatic load_operands();
    logic [CFG_W-1:0] nr, nk, nc;
    nr = used_dim(gen_rows);
    nk = used_dim(gen_inner);
    nc = used_dim(gen_cols);
    for (int i = 0; i < nr; i++)
      for (int k = 0; k < nk; k++)
        if (!a_loaded[i * MAX_DIM + k] || $urandom_range(0, 3) == 0)
          queue_req(ACT_LOAD_A, IDX_W'(i), IDX_W'(k), rand_elem());
    for (int k = 0; k < nk; k++)
      for (int j = 0; j < nc; j++)
        if (!b_loaded[k * MAX_DIM + j] || $urandom_range(0, 3) == 0)
          queue_req(ACT_LOAD_B, IDX_W'(k), IDX_W'(j), rand_elem());
  endtask

  send_t head_req;

  // driver: one request in flight, config writes only once the engine is quiet
  always @(posedge clk_i or negedge rst_ni) begin : driver
    logic  go;
    logic  we;
    send_t head;
    if (!rst_ni) begin
      start_i  <= 1'b0;
      cfg_we_i <= 1'b0;
      settle = 0;
    end else begin
      go = start_i;
      we = 1'b0;
      if (start_i && !busy_o) begin
        engine_step(head_req);
        go = 1'b0;
      end
      if (!go && send_q.size() != 0) begin
        if (send_q[0].kind == SEND_REQ) begin
          if (send_q[0].gap != 0) begin
            send_q[0].gap = send_q[0].gap - 1;
          end else begin
            head            = send_q.pop_front();
            head_req        = head;
            go              = 1'b1;
            action_i        <= head.act;
            row_index_i     <= head.row;
            col_index_i     <= head.col;
            element_value_i <= head.value;
          end
        end else begin
          if (c_entries_due.size() == 0 && busy_o == 1'b0) settle++;
          else settle = 0;
          if (settle > SETTLE_CYCLES) begin
            settle = 0;
            head   = send_q.pop_front();
            if (head.kind == SEND_CFG) begin
              we = 1'b1;
              cfg_idx_i  <= head.cfg_idx;
              cfg_data_i <= head.cfg_val;
              case (head.cfg_idx)
                REG_ROWS_A:    rows_reg  = head.cfg_val;
                REG_INNER_DIM: inner_reg = head.cfg_val;
                REG_COLS_B:    cols_reg  = head.cfg_val;
                default: ;
              endcase
            end
          end
        end
      end
      start_i  <= go;
      cfg_we_i <= we;
    end
  end

  always @(posedge clk_i) begin : monitor
    c_entry_t e;
    if (rst_ni && valid_o === 1'b1) begin
      if (c_entries_due.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected C entry [%0d][%0d] value %0d", out_row_o, out_col_o,
                   product_value_o);
        mismatches++;
      end else begin
        e = c_entries_due.pop_front();
        if (product_value_o !== e.value || out_row_o !== e.row || out_col_o !== e.col ||
            last_o !== e.last) begin
          if (mismatches < 10)
            $display("C entry: expected [%0d][%0d] %0d last %0b, got [%0d][%0d] %0d last %0b",
                     e.row, e.col, e.value, e.last, out_row_o, out_col_o, product_value_o,
                     last_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    // widest sum: one row of A against one column of B, all at the negative limit
    bursty = 1'b1;
    queue_cfg(REG_ROWS_A, 4'd1);
    queue_cfg(REG_INNER_DIM, 4'd8);
    queue_cfg(REG_COLS_B, 4'd0);
    for (int k = 0; k < MAX_DIM; k++) queue_req(ACT_LOAD_A, '0, IDX_W'(k), ELEM_MIN);
    for (int k = 0; k < MAX_DIM; k++) queue_req(ACT_LOAD_B, IDX_W'(k), '0, ELEM_MIN);
    queue_req(ACT_COMPUTE, '0, '0, '0);
    queue_req(ACT_LOAD_A, '0, '0, ELEM_MAX);
    queue_req(ACT_LOAD_A, 3'd7, 3'd7, ELEM_MAX);   // row past rows_a: dropped
    queue_req(ACT_LOAD_B, 3'd7, 3'd7, ELEM_MAX);   // column past cols_b: dropped
    queue_req(ACT_UNUSED, 3'd7, 3'd7, ELEM_MIN);
    queue_hold();
    queue_req(ACT_COMPUTE, 3'd7, 3'd7, ELEM_MAX);

    // upper clamp on the size registers
    queue_cfg(REG_ROWS_A, 4'd15);
    queue_cfg(REG_INNER_DIM, 4'd2);
    queue_cfg(REG_COLS_B, 4'd9);

    while (item_count < ITEMS_TARGET) begin
      quiet  = item_count > ITEMS_TARGET - QUIET_ITEMS;
      bursty = $urandom_range(0, 2) != 0;
      if ($urandom_range(0, 2) == 0) begin
        if ($urandom_range(0, 1) == 0) queue_cfg(REG_ROWS_A, rand_size());
        if ($urandom_range(0, 1) == 0) queue_cfg(REG_INNER_DIM, rand_size());
        if ($urandom_range(0, 1) == 0) queue_cfg(REG_COLS_B, rand_size());
      end
      load_operands();
      repeat ($urandom_range(0, 3)) begin
        case ($urandom_range(0, 4))
          0: queue_req(ACT_UNUSED, IDX_W'($urandom), IDX_W'($urandom), rand_elem());
          1, 2: queue_req(ACT_LOAD_A, IDX_W'($urandom), IDX_W'($urandom), rand_elem());
          default: queue_req(ACT_LOAD_B, IDX_W'($urandom), IDX_W'($urandom), rand_elem());
        endcase
      end
      if ($urandom_range(0, 7) == 0) queue_hold();
      if ($urandom_range(0, 7) != 0)
        queue_req(ACT_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), rand_elem());
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (send_q.size() != 0 || start_i || c_entries_due.size() != 0 || busy_o !== 1'b0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && c_entries_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * 10);
    $display("Mismatches found");
    $finish;
  end

endmodule
